// File: src/m3inv_pkg.sv
package m3inv_pkg;

   // Fixed field widths
   localparam int A_W        = 32;   // input entry and output entry width
   localparam int LANES      = 9;    // matrix entries
   localparam int COF_W      = 65;   // signed cofactor, |x| <= 2^63
   localparam int CMAG_W     = 64;   // cofactor magnitude
   localparam int DET_W      = 98;   // signed exact determinant, |x| < 2^96
   localparam int DMAG_W     = 97;   // determinant magnitude
   localparam int QUO_W      = 32;   // quotient bits resolved by the divider
   localparam int FRAC_BITS_DEF = 16;

   // Per-item values that ride along the divider unchanged
   typedef struct packed {
      logic [A_W-1:0] det;
      logic           singular;
   } side_type;

endpackage

// File: src/m3inv_div.sv
module m3inv_div #(
   parameter int FRAC_BITS = m3inv_pkg::FRAC_BITS_DEF
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            in_valid,
   output logic                                            in_ready,
   input  logic [m3inv_pkg::CMAG_W+2*FRAC_BITS-1:0]        in_rem [m3inv_pkg::LANES],
   input  logic [m3inv_pkg::LANES-1:0]                     in_ovf,
   input  logic [m3inv_pkg::LANES-1:0]                     in_neg,
   input  logic [m3inv_pkg::DMAG_W-1:0]                    in_dmag,
   input  m3inv_pkg::side_type                             in_side,
   output logic                                            out_valid,
   input  logic                                            out_ready,
   output logic [m3inv_pkg::QUO_W-1:0]                     out_q [m3inv_pkg::LANES],
   output logic [m3inv_pkg::LANES-1:0]                     out_ovf,
   output logic [m3inv_pkg::LANES-1:0]                     out_neg,
   output m3inv_pkg::side_type                             out_side
);
   import m3inv_pkg::*;

   localparam int NUM_W = CMAG_W + 2 * FRAC_BITS;
   localparam int CW    = DMAG_W + QUO_W;

   // One restoring step per stage, quotient bit QUO_W-1-s resolved in stage s
   logic              v_ff    [QUO_W];
   logic              rdy     [QUO_W+1];
   logic [NUM_W-1:0]  rem_ff  [QUO_W][LANES];
   logic [QUO_W-1:0]  q_ff    [QUO_W][LANES];
   logic [LANES-1:0]  ovf_ff  [QUO_W];
   logic [LANES-1:0]  neg_ff  [QUO_W];
   logic [DMAG_W-1:0] dmag_ff [QUO_W];
   side_type          side_ff [QUO_W];

   // Stage moves when empty or when the next one moves
   assign rdy[QUO_W] = out_ready;
   for (genvar s = 0; s < QUO_W; s++) begin : g_rdy
      assign rdy[s] = !v_ff[s] || rdy[s+1];
   end
   assign in_ready = rdy[0];

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      logic              v_src;
      logic [NUM_W-1:0]  rem_src [LANES];
      logic [QUO_W-1:0]  q_src   [LANES];
      logic [LANES-1:0]  ovf_src;
      logic [LANES-1:0]  neg_src;
      logic [DMAG_W-1:0] dmag_src;
      side_type          side_src;
      logic [NUM_W-1:0]  rem_in  [LANES];
      logic [QUO_W-1:0]  q_in    [LANES];
      logic [CW-1:0]     dsh;

      if (s == 0) begin : g_first
         assign v_src    = in_valid;
         assign rem_src  = in_rem;
         assign ovf_src  = in_ovf;
         assign neg_src  = in_neg;
         assign dmag_src = in_dmag;
         assign side_src = in_side;
         for (genvar l = 0; l < LANES; l++) begin : g_q0
            assign q_src[l] = '0;
         end
      end else begin : g_next
         assign v_src    = v_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign q_src    = q_ff[s-1];
         assign ovf_src  = ovf_ff[s-1];
         assign neg_src  = neg_ff[s-1];
         assign dmag_src = dmag_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      // Compare and subtract against the divisor shifted to this bit
      always_comb begin
         logic [CW-1:0] rext;
         dsh = CW'(dmag_src) << (QUO_W - 1 - s);
         for (int l = 0; l < LANES; l++) begin
            rext = CW'(rem_src[l]);
            if (rext >= dsh) begin
               rem_in[l] = NUM_W'(rext - dsh);
               q_in[l]   = {q_src[l][QUO_W-2:0], 1'b1};
            end else begin
               rem_in[l] = rem_src[l];
               q_in[l]   = {q_src[l][QUO_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            v_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[s]) begin
            rem_ff[s]  <= rem_in;
            q_ff[s]    <= q_in;
            ovf_ff[s]  <= ovf_src;
            neg_ff[s]  <= neg_src;
            dmag_ff[s] <= dmag_src;
            side_ff[s] <= side_src;
         end
      end
   end

   assign out_valid = v_ff[QUO_W-1];
   assign out_q     = q_ff[QUO_W-1];
   assign out_ovf   = ovf_ff[QUO_W-1];
   assign out_neg   = neg_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

`ifndef SYNTH
   // Final remainder of in-range lane 0 is below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ovf[0] |-> CW'(rem_ff[QUO_W-1][0]) < CW'(dmag_ff[QUO_W-1]))
      else $error("divider remainder not below divisor");
   // Accepted request occupies the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> v_ff[0])
      else $error("accepted request lost at divider entry");
   // Empty output end never blocks the entry
   a_flow: assert property (@(posedge clock) disable iff (reset)
      !out_valid |-> in_ready)
      else $error("divider stalls with empty output");
`endif

endmodule

// File: src/matrix3_inverse_adjugate.sv
// 3x3 matrix inverse by adjugate, signed Q16.16 in and out.
// Pipeline of 7 front stages, 32 divider stages and 1 output register.
// Throughput: one matrix per cycle while rsp_ready does not stall the output;
// the 32-step pipelined restoring divider, one quotient bit per stage, sets depth.
// Reset (synchronous, active high) clears all valid bits; data regs are not reset.
module matrix3_inverse_adjugate #(
   parameter int FRAC_BITS = m3inv_pkg::FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [31:0]        req_a00,
   input  logic signed [31:0]        req_a01,
   input  logic signed [31:0]        req_a02,
   input  logic signed [31:0]        req_a10,
   input  logic signed [31:0]        req_a11,
   input  logic signed [31:0]        req_a12,
   input  logic signed [31:0]        req_a20,
   input  logic signed [31:0]        req_a21,
   input  logic signed [31:0]        req_a22,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [31:0]        rsp_r00,
   output logic signed [31:0]        rsp_r01,
   output logic signed [31:0]        rsp_r02,
   output logic signed [31:0]        rsp_r10,
   output logic signed [31:0]        rsp_r11,
   output logic signed [31:0]        rsp_r12,
   output logic signed [31:0]        rsp_r20,
   output logic signed [31:0]        rsp_r21,
   output logic signed [31:0]        rsp_r22,
   output logic signed [31:0]        rsp_determinant,
   output logic                      rsp_singular
);
   import m3inv_pkg::*;

   localparam int NUM_W = CMAG_W + 2 * FRAC_BITS;
   localparam int CW    = DMAG_W + QUO_W;
   localparam logic [DMAG_W-1:0] POS_MAX = DMAG_W'(32'h7FFF_FFFF);
   localparam logic [DMAG_W-1:0] NEG_MAX = DMAG_W'(33'h0_8000_0000);

   // Front pipeline valid bits and ready chain
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy_out;
   logic div_in_ready, div_out_valid;

   logic rsp_valid_ff;
   assign rdy_out = !rsp_valid_ff || rsp_ready;
   assign rdy7 = !v7_ff || div_in_ready;
   assign rdy6 = !v6_ff || rdy7;
   assign rdy5 = !v5_ff || rdy6;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
         if (rdy6) v6_ff <= v5_ff;
         if (rdy7) v7_ff <= v6_ff;
      end
   end

   // Stage 1: the 18 minor products
   logic signed [31:0] a_in [LANES];
   logic signed [63:0] pa_in [LANES];
   logic signed [63:0] pb_in [LANES];
   logic signed [63:0] pa_ff [LANES];
   logic signed [63:0] pb_ff [LANES];
   logic signed [31:0] row1_ff [3];

   assign a_in[0] = req_a00;
   assign a_in[1] = req_a01;
   assign a_in[2] = req_a02;
   assign a_in[3] = req_a10;
   assign a_in[4] = req_a11;
   assign a_in[5] = req_a12;
   assign a_in[6] = req_a20;
   assign a_in[7] = req_a21;
   assign a_in[8] = req_a22;

   always_comb begin
      int r0, r1, c0, c1;
      for (int i = 0; i < 3; i++) begin
         r0 = (i == 0) ? 1 : 0;
         r1 = (i == 2) ? 1 : 2;
         for (int j = 0; j < 3; j++) begin
            c0 = (j == 0) ? 1 : 0;
            c1 = (j == 2) ? 1 : 2;
            pa_in[i*3+j] = a_in[r0*3+c0] * a_in[r1*3+c1];
            pb_in[i*3+j] = a_in[r0*3+c1] * a_in[r1*3+c0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         pa_ff   <= pa_in;
         pb_ff   <= pb_in;
         row1_ff <= a_in[0:2];
      end
   end

   // Stage 2: signed cofactors with checkerboard sign
   logic signed [COF_W-1:0] cof_in  [LANES];
   logic signed [COF_W-1:0] cof2_ff [LANES];
   logic signed [31:0]      row2_ff [3];

   always_comb begin
      logic signed [COF_W-1:0] m;
      for (int c = 0; c < LANES; c++) begin
         m = COF_W'(pa_ff[c]) - COF_W'(pb_ff[c]);
         cof_in[c] = (((c / 3) + (c % 3)) % 2 == 1) ? -m : m;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         cof2_ff <= cof_in;
         row2_ff <= row1_ff;
      end
   end

   // Stage 3: first-row terms split into two 33x32 partial products
   logic signed [65:0]      ph_in [3];
   logic signed [65:0]      pl_in [3];
   logic signed [65:0]      ph_ff [3];
   logic signed [65:0]      pl_ff [3];
   logic signed [COF_W-1:0] cof3_ff [LANES];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         ph_in[j] = $signed(cof2_ff[j][COF_W-1:32]) * row2_ff[j];
         pl_in[j] = $signed({1'b0, cof2_ff[j][31:0]}) * row2_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         ph_ff   <= ph_in;
         pl_ff   <= pl_in;
         cof3_ff <= cof2_ff;
      end
   end

   // Stage 4: recombine partial products into terms
   logic signed [DET_W-1:0] term_in [3];
   logic signed [DET_W-1:0] term_ff [3];
   logic signed [COF_W-1:0] cof4_ff [LANES];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         term_in[j] = (DET_W'(ph_ff[j]) <<< 32) + DET_W'(pl_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         term_ff <= term_in;
         cof4_ff <= cof3_ff;
      end
   end

   // Stage 5: exact determinant
   logic signed [DET_W-1:0] det_ff;
   logic signed [COF_W-1:0] cof5_ff [LANES];

   always_ff @(posedge clock) begin
      if (rdy5) begin
         det_ff  <= term_ff[0] + term_ff[1] + term_ff[2];
         cof5_ff <= cof4_ff;
      end
   end

   // Stage 6: magnitudes, signs, singular flag, transpose into lanes
   logic [DMAG_W-1:0] dmag_in;
   logic [CMAG_W-1:0] cmag_in [LANES];
   logic [LANES-1:0]  rneg_in;
   logic [DMAG_W-1:0] dmag6_ff;
   logic [CMAG_W-1:0] cmag6_ff [LANES];
   logic [LANES-1:0]  rneg6_ff;
   logic              dneg6_ff;
   logic              sing6_ff;

   always_comb begin
      logic signed [DET_W-1:0] dn;
      logic signed [COF_W-1:0] cn;
      int src;
      dn = -det_ff;
      dmag_in = det_ff[DET_W-1] ? dn[DMAG_W-1:0] : det_ff[DMAG_W-1:0];
      for (int l = 0; l < LANES; l++) begin
         src = (l % 3) * 3 + (l / 3);
         cn = -cof5_ff[src];
         cmag_in[l] = cof5_ff[src][COF_W-1] ? cn[CMAG_W-1:0] : cof5_ff[src][CMAG_W-1:0];
         rneg_in[l] = cof5_ff[src][COF_W-1] ^ det_ff[DET_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy6) begin
         dmag6_ff <= dmag_in;
         cmag6_ff <= cmag_in;
         rneg6_ff <= rneg_in;
         dneg6_ff <= det_ff[DET_W-1];
         sing6_ff <= (det_ff == '0);
      end
   end

   // Stage 7: scaled numerators, overflow check, saturated determinant
   logic [NUM_W-1:0]  num_in [LANES];
   logic [LANES-1:0]  ovf_in;
   logic [A_W-1:0]    dout_in;
   logic [NUM_W-1:0]  num7_ff [LANES];
   logic [LANES-1:0]  ovf7_ff;
   logic [LANES-1:0]  rneg7_ff;
   logic [DMAG_W-1:0] dmag7_ff;
   side_type          side7_ff;

   always_comb begin
      logic [DMAG_W-1:0] dq;
      logic [A_W-1:0]    dlo;
      for (int l = 0; l < LANES; l++) begin
         num_in[l] = NUM_W'(cmag6_ff[l]) << (2 * FRAC_BITS);
         ovf_in[l] = CW'(num_in[l]) >= (CW'(dmag6_ff) << QUO_W);
      end
      dq  = dmag6_ff >> (2 * FRAC_BITS);
      dlo = dq[A_W-1:0];
      if (dneg6_ff) begin
         dout_in = (dq > NEG_MAX) ? {1'b1, {(A_W-1){1'b0}}} : -dlo;
      end else begin
         dout_in = (dq > POS_MAX) ? {1'b0, {(A_W-1){1'b1}}} : dlo;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy7) begin
         num7_ff           <= num_in;
         ovf7_ff           <= ovf_in;
         rneg7_ff          <= rneg6_ff;
         dmag7_ff          <= dmag6_ff;
         side7_ff.det      <= dout_in;
         side7_ff.singular <= sing6_ff;
      end
   end

   // Pipelined divider for all nine entries
   logic [QUO_W-1:0] q_d [LANES];
   logic [LANES-1:0] ovf_d;
   logic [LANES-1:0] neg_d;
   side_type         side_d;

   m3inv_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v7_ff),
      .in_ready  (div_in_ready),
      .in_rem    (num7_ff),
      .in_ovf    (ovf7_ff),
      .in_neg    (rneg7_ff),
      .in_dmag   (dmag7_ff),
      .in_side   (side7_ff),
      .out_valid (div_out_valid),
      .out_ready (rdy_out),
      .out_q     (q_d),
      .out_ovf   (ovf_d),
      .out_neg   (neg_d),
      .out_side  (side_d)
   );

   // Output register: sign, saturate, zero on singular
   logic [A_W-1:0] r_in  [LANES];
   logic [A_W-1:0] r_ff  [LANES];
   logic [A_W-1:0] det_out_ff;
   logic           sing_out_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (side_d.singular) begin
            r_in[l] = '0;
         end else if (neg_d[l]) begin
            r_in[l] = (ovf_d[l] || q_d[l] > {1'b1, {(QUO_W-1){1'b0}}}) ?
                      {1'b1, {(A_W-1){1'b0}}} : -q_d[l];
         end else begin
            r_in[l] = (ovf_d[l] || q_d[l][QUO_W-1]) ?
                      {1'b0, {(A_W-1){1'b1}}} : q_d[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rdy_out) begin
         rsp_valid_ff <= div_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_out) begin
         r_ff        <= r_in;
         det_out_ff  <= side_d.det;
         sing_out_ff <= side_d.singular;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_r00         = r_ff[0];
   assign rsp_r01         = r_ff[1];
   assign rsp_r02         = r_ff[2];
   assign rsp_r10         = r_ff[3];
   assign rsp_r11         = r_ff[4];
   assign rsp_r12         = r_ff[5];
   assign rsp_r20         = r_ff[6];
   assign rsp_r21         = r_ff[7];
   assign rsp_r22         = r_ff[8];
   assign rsp_determinant = det_out_ff;
   assign rsp_singular    = sing_out_ff;

`ifndef SYNTH
   // Singular result carries zero determinant and zero r00, r11, r22, r01, r12, r20
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_determinant == 0 && rsp_r00 == 0 &&
      rsp_r11 == 0 && rsp_r22 == 0 && rsp_r01 == 0 && rsp_r12 == 0 && rsp_r20 == 0)
      else $error("singular result with nonzero fields");
   // Empty output register means every stage can take a request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("request blocked with empty output");
   // Nonzero determinant never marked singular
   a_sing_det: assert property (@(posedge clock) disable iff (reset)
      v6_ff && sing6_ff |-> dmag6_ff == '0)
      else $error("singular flag with nonzero determinant");
`endif

endmodule
